/* src/twg_pkg.sv */
// Shared types and constants of the twiddle gain tuner.
`default_nettype none

package twg_pkg;

    localparam int WORD_W        = 32;
    localparam int CFG_NUM_REGS  = 6;
    localparam int CFG_INDEX_W   = 3;
    localparam int TUNED_INDEX_W = 2;
    localparam int CFG_GAINS     = 3;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_GAIN_P = 3'd0,
        REG_START_GAIN_I = 3'd1,
        REG_START_GAIN_D = 3'd2,
        REG_START_STEP_P = 3'd3,
        REG_START_STEP_I = 3'd4,
        REG_START_STEP_D = 3'd5
    } cfg_index_t;

    typedef word_t [CFG_NUM_REGS-1:0] cfg_bank_t;

    localparam word_t GAIN_RESET  = 32'h0000_0000;
    localparam word_t STEP_RESET  = 32'h0001_0000;
    localparam word_t ERROR_MAX   = 32'hFFFF_FFFF;

    localparam logic REQ_RESTART = 1'b0;
    localparam logic REQ_REPORT  = 1'b1;

    // Multipliers for the step scaling, in tenths.
    localparam int STEP_GROW_TENTHS   = 11;
    localparam int STEP_SHRINK_TENTHS = 9;

    typedef struct packed {
        logic  req_type;
        word_t run_error;
    } req_t;

    typedef struct packed {
        word_t                    gain_p;
        word_t                    gain_i;
        word_t                    gain_d;
        word_t                    min_error;
        logic [TUNED_INDEX_W-1:0] tuned_index;
        logic                     probe_flag;
        word_t                    run_count;
    } res_t;

    // Update command from the input stage to the tuner state.
    typedef struct packed {
        logic  fire;
        logic  restart;
        word_t run_error;
    } update_t;

endpackage

`default_nettype wire

/* src/twg_stream_if.sv */
// Valid/ready stream interface carrying one payload per transfer.
`default_nettype none

interface twg_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* src/twiddle_gain_tuner.sv */
// Top level of the twiddle gain tuner: input stage, result handshake, config and state.
//
//  channel | dir | transfer when        | payload
//  --------+-----+----------------------+--------------------------------------------
//  req     | in  | req.valid & ready    | req_type, run_error
//  res     | out | res.valid & ready    | gain_p/i/d, min_error, tuned_index, ...
//  cfg     | in  | cfg_we               | cfg_index, cfg_wdata (32 bits)
//
// One item per cycle while results are taken; a result is offered after its request
// passes the input register and then the state update that also forms the result.
// The update path is one constant-reciprocal multiply for the step scaling
// followed by at most two saturating adds on the probed gains.
// Reset loads the start registers with their defaults and the tuner state with its
// reset values at once; there is no clearing pass.
// A stalled result holds; one further request waits in the input register.
`default_nettype none

module twiddle_gain_tuner #(
    parameter int NUM_GAINS   = 3,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    twg_stream_if.sink                           req,
    twg_stream_if.source                         res,
    input  wire logic                            cfg_we,
    input  wire logic [twg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire twg_pkg::word_t                  cfg_wdata
);

    twg_pkg::cfg_bank_t cfg_bank;
    twg_pkg::update_t   upd;
    twg_pkg::res_t      result;

    logic          in_valid_reg;
    logic          in_valid_next;
    twg_pkg::req_t in_item_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          advance;
    logic          take;

    twg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .bank      (cfg_bank)
    );

    // Move the held item into the state whenever the result slot is free.
    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || advance;
    assign take      = req.valid && req.ready;

    assign upd.fire      = advance;
    assign upd.restart   = (in_item_reg.req_type == twg_pkg::REQ_RESTART);
    assign upd.run_error = in_item_reg.run_error;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_item_reg <= req.payload;
    end

    twg_core #(
        .NUM_GAINS   (NUM_GAINS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (upd),
        .cfg_bank (cfg_bank),
        .result   (result)
    );

    assign res.valid   = out_valid_reg;
    assign res.payload = result;

endmodule

`default_nettype wire

/* src/twg_cfg_regs.sv */
// Configuration register bank: start gains and start steps.
`default_nettype none

module twg_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [twg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire twg_pkg::word_t                 cfg_wdata,
    output twg_pkg::cfg_bank_t                  bank
);

    twg_pkg::cfg_bank_t bank_reg;
    twg_pkg::cfg_bank_t bank_next;

    always_comb
    begin
        bank_next = bank_reg;
        if (cfg_we)
        begin
            unique case (twg_pkg::cfg_index_t'(cfg_index))
                twg_pkg::REG_START_GAIN_P: bank_next[twg_pkg::REG_START_GAIN_P] = cfg_wdata;
                twg_pkg::REG_START_GAIN_I: bank_next[twg_pkg::REG_START_GAIN_I] = cfg_wdata;
                twg_pkg::REG_START_GAIN_D: bank_next[twg_pkg::REG_START_GAIN_D] = cfg_wdata;
                twg_pkg::REG_START_STEP_P: bank_next[twg_pkg::REG_START_STEP_P] = cfg_wdata;
                twg_pkg::REG_START_STEP_I: bank_next[twg_pkg::REG_START_STEP_I] = cfg_wdata;
                twg_pkg::REG_START_STEP_D: bank_next[twg_pkg::REG_START_STEP_D] = cfg_wdata;
                default: ;  // drop writes beyond the bank
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg[twg_pkg::REG_START_GAIN_P] <= twg_pkg::GAIN_RESET;
            bank_reg[twg_pkg::REG_START_GAIN_I] <= twg_pkg::GAIN_RESET;
            bank_reg[twg_pkg::REG_START_GAIN_D] <= twg_pkg::GAIN_RESET;
            bank_reg[twg_pkg::REG_START_STEP_P] <= twg_pkg::STEP_RESET;
            bank_reg[twg_pkg::REG_START_STEP_I] <= twg_pkg::STEP_RESET;
            bank_reg[twg_pkg::REG_START_STEP_D] <= twg_pkg::STEP_RESET;
        end
        else
        begin
            bank_reg <= bank_next;
        end
    end

    assign bank = bank_reg;

endmodule

`default_nettype wire

/* src/twg_step_scale.sv */
// Step scaling by a constant number of tenths, rounded half away from zero, saturated.
`default_nettype none

module twg_step_scale #(
    parameter int VALUE_WIDTH = 32,
    parameter int FACTOR      = 11
) (
    input  wire logic signed [VALUE_WIDTH-1:0] step,
    output logic signed [VALUE_WIDTH-1:0]      scaled
);

    // magnitude * FACTOR + 5 fits here for FACTOR up to 15
    localparam int MW = VALUE_WIDTH + 4;
    localparam logic [MW+3:0] POW_SHIFT  = (MW+4)'(1) << (MW + 3);
    // ceil(2^(MW+3) / 10): exact floor division by ten for any MW-bit value
    localparam logic [MW+3:0] MAGIC_WIDE = (POW_SHIFT + (MW+4)'(9)) / (MW+4)'(10);
    localparam logic [MW-1:0] MAGIC      = MAGIC_WIDE[MW-1:0];
    localparam logic [MW-1:0] FACTOR_M   = MW'(FACTOR);
    localparam logic [MW-1:0] ROUND_HALF = MW'(5);

    localparam logic [VALUE_WIDTH:0] MAX_MAG = {2'b00, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH:0] MIN_MAG = MAX_MAG + (VALUE_WIDTH+1)'(1);
    localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic [VALUE_WIDTH-1:0] mag;
    logic [MW-1:0]          num;
    logic [2*MW-1:0]        prod;
    logic [VALUE_WIDTH:0]   quo;

    assign mag  = step[VALUE_WIDTH-1] ? VALUE_WIDTH'(-step) : VALUE_WIDTH'(step);
    assign num  = MW'(mag) * FACTOR_M + ROUND_HALF;
    assign prod = (2*MW)'(num) * (2*MW)'(MAGIC);
    assign quo  = prod[2*MW-1:MW+3];

    always_comb
    begin
        if (!step[VALUE_WIDTH-1])
        begin
            scaled = (quo > MAX_MAG) ? VMAX : $signed(quo[VALUE_WIDTH-1:0]);
        end
        else
        begin
            scaled = (quo > MIN_MAG) ? VMIN : -$signed(quo[VALUE_WIDTH-1:0]);
        end
    end

endmodule

`default_nettype wire

/* src/twg_core.sv */
// Tuner state: gains, steps, probe index, best error, improving mark and report count.
`default_nettype none

module twg_core #(
    parameter int NUM_GAINS   = 3,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire twg_pkg::update_t   upd,
    input  wire twg_pkg::cfg_bank_t cfg_bank,
    output twg_pkg::res_t           result
);

    localparam int IDX_W = (NUM_GAINS > 1) ? $clog2(NUM_GAINS) : 1;
    localparam int LW    = (VALUE_WIDTH > twg_pkg::WORD_W) ? VALUE_WIDTH : twg_pkg::WORD_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_GAINS - 1);

    localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [LW-1:0] LMAX = LW'(VMAX);
    localparam logic signed [LW-1:0] LMIN = LW'(VMIN);

    function automatic logic signed [VALUE_WIDTH-1:0] sat_add(
        input logic signed [VALUE_WIDTH-1:0] a,
        input logic signed [VALUE_WIDTH-1:0] b
    );
        logic [VALUE_WIDTH:0] s;
        s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
        if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1])
            return s[VALUE_WIDTH] ? VMIN : VMAX;
        return $signed(s[VALUE_WIDTH-1:0]);
    endfunction

    function automatic logic signed [VALUE_WIDTH-1:0] sat_sub(
        input logic signed [VALUE_WIDTH-1:0] a,
        input logic signed [VALUE_WIDTH-1:0] b
    );
        logic [VALUE_WIDTH:0] s;
        s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
        if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1])
            return s[VALUE_WIDTH] ? VMIN : VMAX;
        return $signed(s[VALUE_WIDTH-1:0]);
    endfunction

    // Sign-extend a 32-bit register value and clamp it to the stored range.
    function automatic logic signed [VALUE_WIDTH-1:0] load_value(input twg_pkg::word_t v);
        logic signed [LW-1:0] ext;
        ext = LW'($signed(v));
        if (ext > LMAX)
            return VMAX;
        if (ext < LMIN)
            return VMIN;
        return ext[VALUE_WIDTH-1:0];
    endfunction

    logic signed [VALUE_WIDTH-1:0] gain_reg  [NUM_GAINS];
    logic signed [VALUE_WIDTH-1:0] gain_next [NUM_GAINS];
    logic signed [VALUE_WIDTH-1:0] step_reg  [NUM_GAINS];
    logic signed [VALUE_WIDTH-1:0] step_next [NUM_GAINS];

    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    twg_pkg::word_t     best_reg;
    twg_pkg::word_t     best_next;
    logic               improving_reg;
    logic               improving_next;
    twg_pkg::word_t     count_reg;
    twg_pkg::word_t     count_next;

    logic                          hit;
    logic [IDX_W-1:0]              idx_adv;
    logic signed [VALUE_WIDTH-1:0] step_cur;
    logic signed [VALUE_WIDTH-1:0] step_up;
    logic signed [VALUE_WIDTH-1:0] step_down;

    assign hit      = upd.run_error < best_reg;
    assign idx_adv  = (idx_reg == LAST_IDX) ? '0 : idx_reg + IDX_W'(1);
    assign step_cur = step_reg[idx_reg];

    twg_step_scale #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FACTOR      (twg_pkg::STEP_GROW_TENTHS)
    ) u_grow (
        .step   (step_cur),
        .scaled (step_up)
    );

    twg_step_scale #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FACTOR      (twg_pkg::STEP_SHRINK_TENTHS)
    ) u_shrink (
        .step   (step_cur),
        .scaled (step_down)
    );

    for (genvar gi = 0; gi < NUM_GAINS; gi++)
    begin : g_lane
        logic                          is_cur;
        logic                          is_adv;
        logic signed [VALUE_WIDTH-1:0] load_gain;
        logic signed [VALUE_WIDTH-1:0] load_step;
        logic signed [VALUE_WIDTH-1:0] restored;
        logic signed [VALUE_WIDTH-1:0] lowered;

        assign is_cur   = (idx_reg == IDX_W'(gi));
        assign is_adv   = (idx_adv == IDX_W'(gi));
        assign restored = sat_add(gain_reg[gi], step_reg[gi]);
        assign lowered  = sat_sub(sat_sub(gain_reg[gi], step_reg[gi]), step_reg[gi]);

        if (gi < twg_pkg::CFG_GAINS)
        begin : g_load
            assign load_gain = load_value(cfg_bank[int'(twg_pkg::REG_START_GAIN_P) + gi]);
            assign load_step = load_value(cfg_bank[int'(twg_pkg::REG_START_STEP_P) + gi]);
        end
        else
        begin : g_zero
            assign load_gain = '0;
            assign load_step = '0;
        end

        always_comb
        begin
            gain_next[gi] = gain_reg[gi];
            step_next[gi] = step_reg[gi];
            if (upd.fire)
            begin
                if (upd.restart)
                begin
                    gain_next[gi] = load_gain;
                    step_next[gi] = load_step;
                end
                else if (hit)
                begin
                    if (is_cur)
                        step_next[gi] = step_up;
                    if (is_adv)
                        gain_next[gi] = sat_add(gain_reg[gi], is_cur ? step_up : step_reg[gi]);
                end
                else if (improving_reg)
                begin
                    if (is_cur)
                        gain_next[gi] = lowered;
                end
                else
                begin
                    // second miss: restore, shrink, then probe the next gain
                    if (is_cur)
                    begin
                        step_next[gi] = step_down;
                        gain_next[gi] = restored;
                    end
                    if (is_adv)
                        gain_next[gi] = sat_add(is_cur ? restored : gain_reg[gi],
                                                is_cur ? step_down : step_reg[gi]);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                gain_reg[gi] <= '0;
                step_reg[gi] <= '0;
            end
            else
            begin
                gain_reg[gi] <= gain_next[gi];
                step_reg[gi] <= step_next[gi];
            end
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        best_next      = best_reg;
        improving_next = improving_reg;
        count_next     = count_reg;
        if (upd.fire)
        begin
            if (upd.restart)
            begin
                idx_next       = '0;
                best_next      = twg_pkg::ERROR_MAX;
                improving_next = 1'b1;
                count_next     = '0;
            end
            else
            begin
                count_next = count_reg + twg_pkg::WORD_W'(1);
                if (hit)
                begin
                    best_next      = upd.run_error;
                    improving_next = 1'b1;
                    idx_next       = idx_adv;
                end
                else if (improving_reg)
                begin
                    improving_next = 1'b0;
                end
                else
                begin
                    improving_next = 1'b1;
                    idx_next       = idx_adv;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            best_reg      <= twg_pkg::ERROR_MAX;
            improving_reg <= 1'b1;
            count_reg     <= '0;
        end
        else
        begin
            idx_reg       <= idx_next;
            best_reg      <= best_next;
            improving_reg <= improving_next;
            count_reg     <= count_next;
        end
    end

    // Result fields: low 32 bits of each stored gain, zero where no gain is stored.
    twg_pkg::word_t gain_word [twg_pkg::CFG_GAINS];

    for (genvar go = 0; go < twg_pkg::CFG_GAINS; go++)
    begin : g_out
        if (go < NUM_GAINS)
        begin : g_used
            logic signed [LW-1:0] ext;
            assign ext           = LW'(gain_reg[go]);
            assign gain_word[go] = ext[twg_pkg::WORD_W-1:0];
        end
        else
        begin : g_unused
            assign gain_word[go] = '0;
        end
    end

    assign result.gain_p      = gain_word[0];
    assign result.gain_i      = gain_word[1];
    assign result.gain_d      = gain_word[2];
    assign result.min_error   = best_reg;
    assign result.tuned_index = twg_pkg::TUNED_INDEX_W'(idx_reg);
    assign result.probe_flag  = improving_reg;
    assign result.run_count   = count_reg;

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= LAST_IDX)
        else $error("probe index beyond the last gain");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        upd.fire && upd.restart |=>
            best_reg == twg_pkg::ERROR_MAX && count_reg == '0 && idx_reg == '0 && improving_reg)
        else $error("restart did not reinitialise the tuner state");

    a_report_counts: assert property (@(posedge clk) disable iff (!rst_n)
        upd.fire && !upd.restart |=> count_reg == $past(count_reg) + twg_pkg::WORD_W'(1))
        else $error("report count did not advance");

    a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        upd.fire && !upd.restart |=> best_reg <= $past(best_reg))
        else $error("best error rose on a report");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !upd.fire |=> $stable(count_reg) && $stable(best_reg) && $stable(idx_reg))
        else $error("tuner state moved without an item");

endmodule

`default_nettype wire
